// ----- sv/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned ValueBits = 64;
  localparam int unsigned MaxOut    = 64;
  localparam int unsigned MaxDigits = 22;
  localparam int unsigned DigW      = 5;
  localparam int unsigned CntW      = 7;
  localparam int unsigned QueueDepth = 2;

  // Last step of the multi-cycle divide by ten
  localparam logic [2:0] DecLastStep = 3'd6;

  localparam logic [1:0] RadixOct = 2'd0;
  localparam logic [1:0] RadixDec = 2'd1;

  localparam int unsigned FlAlt    = 0;
  localparam int unsigned FlZero   = 1;
  localparam int unsigned FlLeft   = 2;
  localparam int unsigned FlBlank  = 3;
  localparam int unsigned FlPlus   = 4;
  localparam int unsigned FlUpper  = 5;
  localparam int unsigned FlSigned = 6;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChPlus  = 8'h2b;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic [ValueBits-1:0] mag;
    logic [1:0]           radix;
    logic                 upper;
    logic [7:0]           sign_ch;
    logic                 has_sign;
    logic [1:0]           prefix;
    logic [CntW-1:0]      lead_sp;
    logic [CntW-1:0]      zero_pad;
    logic [5:0]           prec;
    logic [CntW-1:0]      trail_sp;
    logic                 width_left;
    logic [CntW-1:0]      width;
  } job_t;

  typedef enum logic [2:0] {
    BkIdle, BkConv, BkPlan, BkEmit
  } bk_state_e;

  typedef enum logic [2:0] {
    PhLead, PhSign, PhPre, PhZero, PhDig, PhTrail
  } phase_e;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    begin
      if (d < 4'd10) c = ChZero + {4'd0, d};
      else if (upper) c = 8'h37 + {4'd0, d};
      else c = 8'h57 + {4'd0, d};
      return c;
    end
  endfunction

endpackage

// ----- sv/itoa_front.sv -----
// ----------------------------------------------------------------------------
// itoa_front
// Takes input items, works out sign and magnitude, and queues the job.
// ----------------------------------------------------------------------------
module itoa_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [63:0]                       value_i,
  input  logic [1:0]                        radix_i,
  input  logic [6:0]                        flags_i,
  input  logic [6:0]                        width_i,
  input  logic [5:0]                        precision_i,
  output logic                              job_valid_o,
  input  logic                              job_take_i,
  output itoa_pkg::job_t                    job_o
);

  itoa_pkg::job_t q_mem_q [itoa_pkg::QueueDepth];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  itoa_pkg::job_t job_d;
  logic [itoa_pkg::ValueBits-1:0] raw, mag;
  logic           minus, push, pop;

  // Classify the incoming item
  always_comb begin
    raw   = value_i[itoa_pkg::ValueBits-1:0];
    minus = flags_i[itoa_pkg::FlSigned] & raw[itoa_pkg::ValueBits-1];
    mag   = minus ? (~raw + 1'b1) : raw;
    job_d = '0;
    job_d.mag        = mag;
    job_d.radix      = radix_i;
    job_d.upper      = flags_i[itoa_pkg::FlUpper];
    job_d.has_sign   = minus | flags_i[itoa_pkg::FlPlus] | flags_i[itoa_pkg::FlBlank];
    job_d.sign_ch    = minus ? itoa_pkg::ChMinus :
                       flags_i[itoa_pkg::FlPlus] ? itoa_pkg::ChPlus : itoa_pkg::ChSpace;
    job_d.prec       = precision_i;
    job_d.width      = width_i;
    job_d.width_left = flags_i[itoa_pkg::FlLeft];
    // zero_pad carries the zero flag here; the back part sizes the pads
    job_d.zero_pad   = {6'd0, flags_i[itoa_pkg::FlZero] & ~flags_i[itoa_pkg::FlLeft]};
    if (flags_i[itoa_pkg::FlAlt]) begin
      if (radix_i != itoa_pkg::RadixOct && radix_i != itoa_pkg::RadixDec)
        job_d.prefix = 2'd2;
      else if (radix_i == itoa_pkg::RadixOct && mag != '0)
        job_d.prefix = 2'd1;
    end
  end

  assign in_stall_o  = (cnt_q == 2'(itoa_pkg::QueueDepth));
  assign push        = in_valid_i & ~in_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_take_i & job_valid_o;
  assign job_o       = q_mem_q[rp_q];

  // Hold queued jobs
  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wp_q] <= job_d;
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(itoa_pkg::QueueDepth)) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("pointer mismatch");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
`endif

endmodule

// ----- sv/itoa_back.sv -----
// ----------------------------------------------------------------------------
// itoa_back
// Converts the magnitude to digits (one per cycle for octal and hex; for
// decimal each digit takes a multi-step divide by ten) and emits the characters.
// ----------------------------------------------------------------------------
module itoa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  output logic           job_take_o,
  input  itoa_pkg::job_t job_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     ch_o,
  output logic           last_o
);

  itoa_pkg::bk_state_e state_q, state_d;
  itoa_pkg::phase_e    ph_q, ph_d;
  itoa_pkg::job_t      job_q;
  logic [itoa_pkg::ValueBits-1:0] t_q;
  logic [3:0]          dig_q [itoa_pkg::MaxDigits];
  logic [itoa_pkg::DigW-1:0] nd_q;
  logic [itoa_pkg::CntW-1:0] left_q, emitted_q, total_q;
  logic [7:0]          ch_q;
  logic                valid_q, last_q;

  // Divide by ten in steps: reciprocal series, then one correction
  logic [2:0]                     dstep_q;
  logic [itoa_pkg::ValueBits-1:0] acc_q, acc_d, qest;
  logic [4:0]                     r_q, r_d;
  logic                           step_done;
  always_comb begin
    qest  = acc_q >> 3;
    acc_d = acc_q;
    r_d   = r_q;
    case (dstep_q)
      3'd0: acc_d = (t_q >> 1) + (t_q >> 2);
      3'd1: acc_d = acc_q + (acc_q >> 4);
      3'd2: acc_d = acc_q + (acc_q >> 8);
      3'd3: acc_d = acc_q + (acc_q >> 16);
      3'd4: acc_d = acc_q + (acc_q >> 32);
      3'd5: begin
        acc_d = qest;
        r_d   = 5'(t_q - (qest << 3) - (qest << 1));
      end
      default: ;
    endcase
  end

  assign step_done = (job_q.radix != itoa_pkg::RadixDec) | (dstep_q == itoa_pkg::DecLastStep);

  // Divide step: shift for octal and hex, corrected estimate for decimal
  logic [itoa_pkg::ValueBits-1:0] quo;
  logic [3:0]          rem;
  always_comb begin
    quo  = '0;
    rem  = '0;
    if (job_q.radix == itoa_pkg::RadixOct) begin
      quo = t_q >> 3;
      rem = {1'b0, t_q[2:0]};
    end else if (job_q.radix == itoa_pkg::RadixDec) begin
      // the estimate is low by at most one, so the remainder stays below 20
      quo = acc_q + itoa_pkg::ValueBits'(r_q > 5'd9);
      rem = (r_q > 5'd9) ? 4'(r_q - 5'd10) : r_q[3:0];
    end else begin
      quo = t_q >> 4;
      rem = t_q[3:0];
    end
  end

  // Field size arithmetic
  logic [itoa_pkg::CntW-1:0] body, dcount, pad;
  always_comb begin
    dcount = ({1'b0, job_q.prec} > {2'd0, nd_q}) ? {1'b0, job_q.prec} : {2'd0, nd_q};
    body   = dcount + {6'd0, job_q.has_sign} + {5'd0, job_q.prefix};
    pad    = (job_q.width > body) ? job_q.width - body : '0;
  end

  logic out_free, emit, leave;
  logic [7:0] ch_n;
  assign out_free   = ~valid_q | ~out_stall_i;
  assign job_take_o = (state_q == itoa_pkg::BkIdle) & job_valid_i;

  // Pick the next character and phase
  always_comb begin
    ph_d  = ph_q;
    ch_n  = itoa_pkg::ChSpace;
    emit  = 1'b0;
    leave = 1'b0;
    case (ph_q)
      itoa_pkg::PhLead: begin
        if (left_q != '0) begin ch_n = itoa_pkg::ChSpace; emit = 1'b1; end
        else ph_d = itoa_pkg::PhSign;
      end
      itoa_pkg::PhSign: begin
        ph_d = itoa_pkg::PhPre;
        if (job_q.has_sign) begin ch_n = job_q.sign_ch; emit = 1'b1; end
      end
      itoa_pkg::PhPre: begin
        if (left_q != '0) begin
          emit = 1'b1;
          ch_n = (left_q == 7'd1 && job_q.prefix == 2'd2) ?
                 (job_q.upper ? 8'h58 : 8'h78) : itoa_pkg::ChZero;
        end else ph_d = itoa_pkg::PhZero;
      end
      itoa_pkg::PhZero: begin
        if (left_q != '0) begin ch_n = itoa_pkg::ChZero; emit = 1'b1; end
        else ph_d = itoa_pkg::PhDig;
      end
      itoa_pkg::PhDig: begin
        if (left_q != '0) begin
          emit = 1'b1;
          ch_n = itoa_pkg::digit_char(dig_q[itoa_pkg::DigW'(left_q - 7'd1)], job_q.upper);
        end else ph_d = itoa_pkg::PhTrail;
      end
      itoa_pkg::PhTrail: begin
        if (left_q != '0) begin ch_n = itoa_pkg::ChSpace; emit = 1'b1; end
        else leave = 1'b1;
      end
      default: leave = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::BkIdle: if (job_valid_i) state_d = itoa_pkg::BkConv;
      itoa_pkg::BkConv: if (step_done && quo == '0) state_d = itoa_pkg::BkPlan;
      itoa_pkg::BkPlan: state_d = itoa_pkg::BkEmit;
      itoa_pkg::BkEmit: if (leave || (emit && out_free && emitted_q + 7'd1 == total_q))
                          state_d = itoa_pkg::BkIdle;
      default: state_d = itoa_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= itoa_pkg::BkIdle;
    else state_q <= state_d;
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      itoa_pkg::BkIdle: begin
        job_q <= job_i; t_q <= job_i.mag; nd_q <= '0; dstep_q <= '0;
      end
      itoa_pkg::BkConv: begin
        if (step_done) begin
          dig_q[nd_q] <= rem; nd_q <= nd_q + 1'b1; t_q <= quo; dstep_q <= '0;
        end else begin
          dstep_q <= dstep_q + 3'd1; acc_q <= acc_d; r_q <= r_d;
        end
      end
      itoa_pkg::BkPlan: begin
        total_q   <= (body + pad > 7'(itoa_pkg::MaxOut)) ? 7'(itoa_pkg::MaxOut) : body + pad;
        emitted_q <= '0;
        job_q.trail_sp <= job_q.width_left ? pad : '0;
        job_q.zero_pad <= job_q.zero_pad[0] ? pad : '0;
        job_q.lead_sp  <= (!job_q.width_left && !job_q.zero_pad[0]) ? pad : '0;
        left_q <= (!job_q.width_left && !job_q.zero_pad[0]) ? pad : '0;
        ph_q   <= itoa_pkg::PhLead;
      end
      itoa_pkg::BkEmit: begin
        if (emit) begin
          if (out_free) begin
            // the sign is a single character: move on to the prefix at once
            if (ph_q == itoa_pkg::PhSign) begin
              ph_q   <= ph_d;
              left_q <= {5'd0, job_q.prefix};
            end else begin
              left_q <= left_q - 7'd1;
            end
            emitted_q <= emitted_q + 7'd1;
          end
        end else begin
          ph_q <= ph_d;
          case (ph_d)
            itoa_pkg::PhPre:   left_q <= {5'd0, job_q.prefix};
            itoa_pkg::PhZero:  left_q <= job_q.zero_pad + ({1'b0, job_q.prec} > {2'd0, nd_q} ?
                                         {1'b0, job_q.prec} - {2'd0, nd_q} : '0);
            itoa_pkg::PhDig:   left_q <= {2'd0, nd_q};
            itoa_pkg::PhTrail: left_q <= job_q.trail_sp;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (state_q == itoa_pkg::BkEmit && emit && out_free) begin
      ch_q <= ch_n; last_q <= (emitted_q + 7'd1 == total_q);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (out_free) valid_q <= (state_q == itoa_pkg::BkEmit) & emit;
  end

  assign out_valid_o = valid_q;
  assign ch_o        = ch_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_stall_i |=> valid_q && $stable(ch_q)) else $error("output dropped");
  a_ndig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itoa_pkg::BkConv |-> nd_q < itoa_pkg::DigW'(itoa_pkg::MaxDigits))
    else $error("digit overflow");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take_o |-> state_q == itoa_pkg::BkIdle) else $error("take while busy");
`endif

endmodule

// ----- sv/integer_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style integer to ASCII conversion, one character per output item.
// ----------------------------------------------------------------------------
// channel | signals                                      | direction
// in      | in_valid_i, in_stall_o, value/radix/flags/width/precision | input
// out     | out_valid_o, out_stall_i, ch_o, last_o       | output
//
// A number is taken from the queue, then converted one digit per cycle for
// octal and hex (up to 22); decimal digits (up to 20) each take a multi-step
// divide by ten. The field is then sized, and characters are emitted one per
// cycle while the output is not stalled (at most 64), with steps between
// fields. A two-entry job queue lets new items be taken while one number is
// emitted.
// Reset clears the queue and the sequencer; out stall holds the output item.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_i,
  input  logic [1:0]  radix_i,
  input  logic [6:0]  flags_i,
  input  logic [6:0]  width_i,
  input  logic [5:0]  precision_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  ch_o,
  output logic        last_o
);

  logic           job_valid, job_take;
  itoa_pkg::job_t job;

  itoa_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .value_i, .radix_i, .flags_i,
    .width_i, .precision_i, .job_valid_o(job_valid), .job_take_i(job_take),
    .job_o(job)
  );

  itoa_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_take_o(job_take), .job_i(job),
    .out_valid_o, .out_stall_i, .ch_o, .last_o
  );

endmodule

// ----- test/itoa_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// itoa_checker
// Watches both channels of the formatter, builds the expected character
// string for every accepted number and compares each output item in order.
// ----------------------------------------------------------------------------
module itoa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] value_i,
  input  logic [1:0]  radix_i,
  input  logic [6:0]  flags_i,
  input  logic [6:0]  width_i,
  input  logic [5:0]  precision_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  char_t exp_chars[$];
  int    fails = 0;

  // Build the printed text of one number and queue its characters.
  task automatic format_number(input logic [63:0] value, input logic [1:0] radix,
                               input logic [6:0] fl, input logic [6:0] width,
                               input logic [5:0] prec);
    logic [63:0] mag;
    logic [63:0] base;
    logic [7:0]  digs[$];
    logic [7:0]  txt[$];
    logic [3:0]  d;
    logic        minus;
    logic        has_sign;
    int          prefix;
    int          nchars;
    int          pad;
    int          tot;
    begin
      mag = value;
      minus = 1'b0;
      prefix = 0;
      base = (radix == itoa_pkg::RadixOct) ? 64'd8 :
             (radix == itoa_pkg::RadixDec) ? 64'd10 : 64'd16;
      if (fl[itoa_pkg::FlSigned] && mag[63]) begin
        minus = 1'b1;
        mag = ~mag + 64'd1;
      end
      do begin
        d = 4'(mag % base);
        digs.push_front(d < 10 ? 8'h30 + d : (fl[itoa_pkg::FlUpper] ? 8'h37 : 8'h57) + d);
        mag = mag / base;
      end while (mag != 0);
      mag = minus ? ~value + 64'd1 : value;
      has_sign = minus || fl[itoa_pkg::FlPlus] || fl[itoa_pkg::FlBlank];
      if (fl[itoa_pkg::FlAlt]) begin
        if (base == 64'd16) prefix = 2;
        else if (base == 64'd8 && mag != 0) prefix = 1;
      end
      nchars = (int'(prec) > digs.size() ? int'(prec) : digs.size()) + has_sign + prefix;
      pad = int'(width) > nchars ? int'(width) - nchars : 0;
      if (!fl[itoa_pkg::FlLeft] && !fl[itoa_pkg::FlZero])
        repeat (pad) txt.push_back(itoa_pkg::ChSpace);
      if (minus) txt.push_back(itoa_pkg::ChMinus);
      else if (fl[itoa_pkg::FlPlus]) txt.push_back(itoa_pkg::ChPlus);
      else if (fl[itoa_pkg::FlBlank]) txt.push_back(itoa_pkg::ChSpace);
      if (prefix >= 1) txt.push_back(itoa_pkg::ChZero);
      if (prefix == 2) txt.push_back(fl[itoa_pkg::FlUpper] ? 8'h58 : 8'h78);
      if (!fl[itoa_pkg::FlLeft] && fl[itoa_pkg::FlZero])
        repeat (pad) txt.push_back(itoa_pkg::ChZero);
      if (int'(prec) > digs.size())
        repeat (int'(prec) - digs.size()) txt.push_back(itoa_pkg::ChZero);
      foreach (digs[k]) txt.push_back(digs[k]);
      if (fl[itoa_pkg::FlLeft]) repeat (pad) txt.push_back(itoa_pkg::ChSpace);
      tot = txt.size() > itoa_pkg::MaxOut ? itoa_pkg::MaxOut : txt.size();
      for (int k = 0; k < tot; k++) exp_chars.push_back('{txt[k], k == tot - 1});
    end
  endtask

  assign fail_count_o = fails;
  assign pending_o = exp_chars.size();

  // Predict on accepted numbers, compare accepted characters.
  always @(posedge clk_i) begin
    char_t e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        format_number(value_i, radix_i, flags_i, width_i, precision_i);
      if (out_valid_i && !out_stall_i) begin
        if (exp_chars.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected item ch=%h last=%b", ch_i, last_i);
        end else begin
          e = exp_chars.pop_front();
          if (e.ch !== ch_i || e.last !== last_i) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp ch=%h last=%b got ch=%h last=%b",
                       e.ch, e.last, ch_i, last_i);
          end
        end
      end
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random numbers into the formatter under four idling
// phases and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] value_i = '0;
  logic [1:0]  radix_i = '0;
  logic [6:0]  flags_i = '0;
  logic [6:0]  width_i = '0;
  logic [5:0]  precision_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  ch_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  always #4 clk_i = ~clk_i;

  integer_to_ascii_formatter i_dut (.*);

  itoa_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .value_i, .radix_i,
    .flags_i, .width_i, .precision_i, .out_valid_i(out_valid_o), .out_stall_i,
    .ch_i(ch_o), .last_i(last_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Toggle receiver stall at random.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // Offer one number, with random gaps, and hold it until accepted.
  // Valid stays high after acceptance; the caller drops it when done.
  task automatic send_number(input logic [63:0] v, input logic [1:0] r,
                             input logic [6:0] f, input logic [6:0] w,
                             input logic [5:0] p);
    begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      value_i <= v;
      radix_i <= r;
      flags_i <= f;
      width_i <= w;
      precision_i <= p;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(20));
      2: return 64'h8000_0000_0000_0000;
      3: return ~64'($urandom_range(20));
      default: return {$urandom, $urandom} >> $urandom_range(63);
    endcase
  endfunction

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: extremes, signs, prefixes, padding rules, overflow to 64 chars.
    send_number(64'd0, 2'd1, 7'h00, 7'd0, 6'd0);
    send_number(64'd0, 2'd0, 7'h01, 7'd0, 6'd0);
    send_number(64'd0, 2'd2, 7'h21, 7'd5, 6'd0);
    send_number('1, 2'd1, 7'h00, 7'd0, 6'd0);
    send_number('1, 2'd1, 7'h40, 7'd0, 6'd0);
    send_number(64'h8000_0000_0000_0000, 2'd1, 7'h40, 7'd0, 6'd0);
    send_number('1, 2'd0, 7'h01, 7'd0, 6'd0);
    send_number(64'hdead_beef, 2'd2, 7'h21, 7'd20, 6'd0);
    send_number(64'hdead_beef, 2'd3, 7'h01, 7'd0, 6'd0);
    send_number(64'd42, 2'd1, 7'h18, 7'd6, 6'd0);
    send_number(64'd42, 2'd1, 7'h08, 7'd6, 6'd0);
    send_number(64'd42, 2'd1, 7'h06, 7'd8, 6'd0);
    send_number(64'd42, 2'd1, 7'h12, 7'd8, 6'd0);
    send_number(64'd42, 2'd2, 7'h03, 7'd10, 6'd4);
    send_number(-64'sd7, 2'd1, 7'h42, 7'd64, 6'd60);
    send_number(64'd9, 2'd0, 7'h01, 7'd64, 6'd60);
    send_number(64'd123, 2'd1, 7'h14, 7'd64, 6'd3);
    send_number(64'd5, 2'd1, 7'h10, 7'd0, 6'd60);
    send_number(64'd5, 2'd1, 7'h00, 7'd127, 6'd63);
    in_valid_i <= 1'b0;
    // Hold off until the formatter has drained.
    while (pending != 0) @(negedge clk_i);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 60 : 33) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 60 : 33) : 0;
      for (int i = 0; i < 120; i++)
        send_number(rand_value(), 2'($urandom), 7'($urandom),
                    ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(24)),
                    ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(12)));
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) $display("[integer_to_ascii_formatter] OK");
    else $display("[integer_to_ascii_formatter] ERROR");
    $finish;
  end

  // Bound the run well past the slowest legal case.
  initial begin
    #20ms;
    $display("[integer_to_ascii_formatter] ERROR");
    $finish;
  end

endmodule
